// ===== hdl/q_table_update_engine_assert.svh =====
// ----------------------------------------------------------------------------
// q_table_update_engine_assert.svh
// Assertion macros shared by the Q-table update engine modules.
// ----------------------------------------------------------------------------
`ifndef Q_TABLE_UPDATE_ENGINE_ASSERT_SVH
`define Q_TABLE_UPDATE_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define QTU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define QTU_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define QTU_ASSERT(name, prop, msg)
`define QTU_ASSERT_NR(name, prop, msg)
`endif

`endif

// ===== hdl/qtu_pkg.sv =====
// ----------------------------------------------------------------------------
// qtu_pkg
// Types and constants of the Q-table update engine.
// ----------------------------------------------------------------------------
package qtu_pkg;

  localparam int DEF_NUM_STATES  = 64;
  localparam int DEF_NUM_ACTIONS = 4;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int RATE_W    = 13;
  localparam int FRAC_BITS = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [RATE_W-1:0] RATE_ONE = 13'd4096;
  localparam logic [RATE_W-1:0] LR_RESET = 13'd2048;
  localparam logic [RATE_W-1:0] DR_RESET = 13'd2867;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARNING_RATE = 1'b0,
    REG_DISCOUNT_RATE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic mul1;
    logic tgt;
    logic mul2;
    logic wb;
    logic clr_start;
    logic clr_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic clr_last;
    logic is_update;
  } dp_sts_t;

endpackage

// ===== hdl/qtu_ram.sv =====
// ----------------------------------------------------------------------------
// qtu_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module qtu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/qtu_ctrl.sv =====
// ----------------------------------------------------------------------------
// qtu_ctrl
// Sequencer: table sweep, row scan, update arithmetic and result hand-off.
// ----------------------------------------------------------------------------
`include "q_table_update_engine_assert.svh"

module qtu_ctrl import qtu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_MUL1,
    S_TGT,
    S_MUL2,
    S_WB,
    S_CLEAR,
    S_DONE
  } state_e;

  state_e  state_q;
  logic    in_stall_q;
  logic    out_valid_q;
  logic    accept;
  dp_cmd_t cmd;

  assign accept = in_valid_i && !in_stall_q;

  always_comb begin
    cmd = '0;
    unique case (state_q) inside
      S_INIT, S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (op_i) inside
            OP_UPDATE, OP_QUERY: cmd.scan_start = 1'b1;
            OP_CLEAR:            cmd.clr_start  = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN:     cmd.scan_step = 1'b1;
      S_MUL1:     cmd.mul1      = 1'b1;
      S_TGT:      cmd.tgt       = 1'b1;
      S_MUL2:     cmd.mul2      = 1'b1;
      S_WB:       cmd.wb        = 1'b1;
      S_DONE:     cmd.out_load  = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      in_stall_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !cmd.out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          if (sts_i.clr_last) begin
            state_q    <= S_IDLE;
            in_stall_q <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            in_stall_q <= 1'b1;
            case (op_i) inside
              OP_UPDATE, OP_QUERY: state_q <= S_SCAN;
              OP_CLEAR:            state_q <= S_CLEAR;
              default:             state_q <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (sts_i.scan_last) begin
            state_q <= S_SCAN_END;
          end
        end
        S_SCAN_END: state_q <= sts_i.is_update ? S_MUL1 : S_DONE;
        S_MUL1:     state_q <= S_TGT;
        S_TGT:      state_q <= S_MUL2;
        S_MUL2:     state_q <= S_WB;
        S_WB:       state_q <= S_DONE;
        S_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd.out_load) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            in_stall_q  <= 1'b0;
          end
        end
        default: state_q <= S_INIT;
      endcase
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

  `QTU_ASSERT(a_wb_after_mul, (state_q == S_WB) |-> ($past(state_q) == S_MUL2), "write-back out of order")
  `QTU_ASSERT(a_busy_stalls, (state_q != S_IDLE) |-> in_stall_q, "request taken while busy")
  `QTU_ASSERT(a_result_from_done, $rose(out_valid_q) |-> ($past(state_q) == S_DONE), "stray result")

endmodule

// ===== hdl/qtu_dp.sv =====
// ----------------------------------------------------------------------------
// qtu_dp
// Datapath: Q table, row maximum, update arithmetic and result register.
// ----------------------------------------------------------------------------
`include "q_table_update_engine_assert.svh"

module qtu_dp import qtu_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_ACTIONS = DEF_NUM_ACTIONS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dp_cmd_t                          cmd_i,
  output dp_sts_t                          sts_o,
  input  logic                             cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [RATE_W-1:0]                cfg_data_i,
  input  logic [1:0]                       op_i,
  input  logic [$clog2(NUM_STATES)-1:0]    cur_state_i,
  input  logic [$clog2(NUM_ACTIONS)-1:0]   taken_action_i,
  input  logic [$clog2(NUM_STATES)-1:0]    next_state_i,
  input  logic signed [VALUE_WIDTH-1:0]    reward_value_i,
  output logic [$clog2(NUM_ACTIONS)-1:0]   best_action_o,
  output logic signed [VALUE_WIDTH-1:0]    best_value_o,
  output logic signed [VALUE_WIDTH-1:0]    written_value_o,
  output logic                             saturated_o
);

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int ACT_W   = $clog2(NUM_ACTIONS);
  localparam int DEPTH   = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int VW      = VALUE_WIDTH;
  localparam int P1_W    = VW + RATE_W + 1;
  localparam int D_W     = VW + 3;
  localparam int P2_W    = D_W + RATE_W + 1;
  localparam int N_W     = VW + 4;

  // request fields
  logic [1:0]           op_q;
  logic [STATE_W-1:0]   cur_q;
  logic [STATE_W-1:0]   nxt_q;
  logic [ACT_W-1:0]     act_q;
  logic signed [VW-1:0] reward_q;

  logic [RATE_W-1:0]    lr_q;
  logic [RATE_W-1:0]    dr_q;
  logic [RATE_W-1:0]    cfg_rate;

  logic [ACT_W-1:0]     scan_cnt_q;
  logic [ADDR_W-1:0]    clr_cnt_q;
  logic                 cmp_vld_q;
  logic [ACT_W-1:0]     cmp_act_q;
  logic [ACT_W-1:0]     best_act_q;
  logic signed [VW-1:0] best_q;

  logic signed [VW-1:0]   q_q;
  logic signed [P1_W-1:0] prod1_q;
  logic signed [D_W-1:0]  diff_q;
  logic signed [P2_W-1:0] prod2_q;
  logic signed [VW-1:0]   nv_q;
  logic                   sat_q;

  logic [ACT_W-1:0]     out_act_q;
  logic signed [VW-1:0] out_best_q;
  logic signed [VW-1:0] out_written_q;
  logic                 out_sat_q;

  logic [STATE_W-1:0]     cur_row;
  logic [STATE_W-1:0]     nxt_row;
  logic [STATE_W-1:0]     scan_row;
  logic [ACT_W-1:0]       act_col;
  logic [ADDR_W-1:0]      cur_addr;
  logic [ADDR_W-1:0]      scan_addr;
  logic [ADDR_W-1:0]      raddr;
  logic [ADDR_W-1:0]      waddr;
  logic [VW-1:0]          wdata;
  logic                   we;
  logic [VW-1:0]          rdata;
  logic signed [VW-1:0]   rval;
  logic signed [P1_W-1:0] sh1;
  logic signed [D_W-1:0]  diff_d;
  logic signed [P2_W-1:0] sh2;
  logic signed [N_W-1:0]  nv;
  logic                   nv_fits;
  logic signed [VW-1:0]   nv_sat;

  // indices wrap once; a power-of-two count folds to no change
  assign cur_row  = (cur_q >= STATE_W'(NUM_STATES)) ? cur_q - STATE_W'(NUM_STATES) : cur_q;
  assign nxt_row  = (nxt_q >= STATE_W'(NUM_STATES)) ? nxt_q - STATE_W'(NUM_STATES) : nxt_q;
  assign act_col  = (act_q >= ACT_W'(NUM_ACTIONS)) ? act_q - ACT_W'(NUM_ACTIONS) : act_q;
  assign scan_row = (op_q == OP_UPDATE) ? nxt_row : cur_row;

  assign cur_addr  = ADDR_W'(cur_row) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(act_col);
  assign scan_addr = ADDR_W'(scan_row) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(scan_cnt_q);
  assign raddr     = cmd_i.scan_step ? scan_addr : cur_addr;

  assign we    = cmd_i.wb || cmd_i.clr_step;
  assign waddr = cmd_i.wb ? cur_addr : clr_cnt_q;
  assign wdata = cmd_i.wb ? nv_sat : '0;

  qtu_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rval = $signed(rdata);

  // arithmetic shifts give floor rounding
  assign sh1    = prod1_q >>> FRAC_BITS;
  assign diff_d = D_W'(reward_q) + $signed(sh1[D_W-1:0]) - D_W'(q_q);
  assign sh2    = prod2_q >>> FRAC_BITS;
  assign nv     = N_W'(q_q) + $signed(sh2[N_W-1:0]);

  assign nv_fits = (&nv[N_W-1:VW-1]) || !(|nv[N_W-1:VW-1]);
  assign nv_sat  = nv_fits ? nv[VW-1:0] :
                   (nv[N_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});

  assign cfg_rate = (cfg_data_i > RATE_ONE) ? RATE_ONE : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q       <= LR_RESET;
      dr_q       <= DR_RESET;
      scan_cnt_q <= '0;
      clr_cnt_q  <= '0;
      cmp_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_LEARNING_RATE: lr_q <= cfg_rate;
          REG_DISCOUNT_RATE: dr_q <= cfg_rate;
          default: ;
        endcase
      end
      if (cmd_i.scan_start) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      if (cmd_i.clr_start) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      cmp_vld_q <= cmd_i.scan_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      cur_q    <= cur_state_i;
      act_q    <= taken_action_i;
      nxt_q    <= next_state_i;
      reward_q <= reward_value_i;
    end
    cmp_act_q <= scan_cnt_q;
    // strict compare keeps the lowest index on ties
    if (cmp_vld_q && (cmp_act_q == '0 || rval > best_q)) begin
      best_q     <= rval;
      best_act_q <= cmp_act_q;
    end
    if (cmd_i.mul1) begin
      q_q     <= rval;
      prod1_q <= P1_W'($signed({1'b0, dr_q})) * P1_W'(best_q);
    end
    if (cmd_i.tgt) begin
      diff_q <= diff_d;
    end
    if (cmd_i.mul2) begin
      prod2_q <= P2_W'($signed({1'b0, lr_q})) * P2_W'(diff_q);
    end
    if (cmd_i.wb) begin
      nv_q  <= nv_sat;
      sat_q <= !nv_fits;
    end
    if (cmd_i.out_load) begin
      case (op_q)
        OP_UPDATE: begin
          out_act_q     <= best_act_q;
          out_best_q    <= best_q;
          out_written_q <= nv_q;
          out_sat_q     <= sat_q;
        end
        OP_QUERY: begin
          out_act_q     <= best_act_q;
          out_best_q    <= best_q;
          out_written_q <= '0;
          out_sat_q     <= 1'b0;
        end
        default: begin
          out_act_q     <= '0;
          out_best_q    <= '0;
          out_written_q <= '0;
          out_sat_q     <= 1'b0;
        end
      endcase
    end
  end

  assign sts_o.scan_last = (scan_cnt_q == ACT_W'(NUM_ACTIONS - 1));
  assign sts_o.clr_last  = (clr_cnt_q == ADDR_W'(DEPTH - 1));
  assign sts_o.is_update = (op_q == OP_UPDATE);

  assign best_action_o   = out_act_q;
  assign best_value_o    = out_best_q;
  assign written_value_o = out_written_q;
  assign saturated_o     = out_sat_q;

  `QTU_ASSERT(a_scan_range, cmd_i.scan_step |-> (scan_cnt_q <= ACT_W'(NUM_ACTIONS - 1)), "scan past row end")
  `QTU_ASSERT_NR(a_one_writer, !(cmd_i.wb && cmd_i.clr_step), "write-back during sweep")
  `QTU_ASSERT(a_cmp_follows_scan, cmp_vld_q |-> $past(cmd_i.scan_step), "compare without read")

endmodule

// ===== hdl/q_table_update_engine.sv =====
// ----------------------------------------------------------------------------
// q_table_update_engine
// Tabular Q-learning update engine: update, best-action query and clear.
// Update: the row maximum comes from a row scan of one entry per cycle on the
//   single read port, followed by the update arithmetic.
// One request at a time; a new one is taken while the result still waits.
// Reset: the table is swept to zero, one entry a cycle, with requests
//   stalled meanwhile.
// ----------------------------------------------------------------------------
module q_table_update_engine import qtu_pkg::*; #(
  parameter int NUM_STATES  = DEF_NUM_STATES,
  parameter int NUM_ACTIONS = DEF_NUM_ACTIONS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]             cfg_index_i,
  input  logic [RATE_W-1:0]                cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [$clog2(NUM_STATES)-1:0]    cur_state_i,
  input  logic [$clog2(NUM_ACTIONS)-1:0]   taken_action_i,
  input  logic [$clog2(NUM_STATES)-1:0]    next_state_i,
  input  logic signed [VALUE_WIDTH-1:0]    reward_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [$clog2(NUM_ACTIONS)-1:0]   best_action_o,
  output logic signed [VALUE_WIDTH-1:0]    best_value_o,
  output logic signed [VALUE_WIDTH-1:0]    written_value_o,
  output logic                             saturated_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  qtu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qtu_dp #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .cur_state_i     (cur_state_i),
    .taken_action_i  (taken_action_i),
    .next_state_i    (next_state_i),
    .reward_value_i  (reward_value_i),
    .best_action_o   (best_action_o),
    .best_value_o    (best_value_o),
    .written_value_o (written_value_o),
    .saturated_o     (saturated_o)
  );

endmodule
